/* rtl/clnib_pkg.sv */
package clnib_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SHORT_WAIT = 2'd0,
        CFG_LONG_WAIT  = 2'd1,
        CFG_POWER_WAIT = 2'd2
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W  = 20;
    localparam int unsigned WAIT_W      = 20;
    localparam int unsigned PTR_W       = 6;
    localparam int unsigned PROG_LEN    = 28;

    localparam logic [15:0] SHORT_WAIT_RESET = 16'd50;
    localparam logic [15:0] LONG_WAIT_RESET  = 16'd2000;
    localparam logic [19:0] POWER_WAIT_RESET = 20'd1000000;

    // Pin register layout: RS, EN, D7..D4.
    localparam int unsigned PIN_RS_BIT = 5;
    localparam int unsigned PIN_EN_BIT = 4;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_INIT    = 3'd1,
        MODE_CLEAR   = 3'd2,
        MODE_CHAR    = 3'd3,
        MODE_NEWLINE = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        CMD_IDLE    = 3'd0,
        CMD_INIT    = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_CHAR    = 3'd3,
        CMD_NEWLINE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_CMD    = 2'd1,
        KIND_IGNORE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_END = 3'd0,
        OP_HI  = 3'd1,
        OP_LO  = 3'd2,
        OP_CH  = 3'd3,
        OP_CL  = 3'd4,
        OP_SW  = 3'd5,
        OP_LW  = 3'd6,
        OP_PW  = 3'd7
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] nib;
    } step_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic       reg_select;
        logic       enable_pin;
        logic [3:0] data_nibble;
        logic       backlight;
        logic       busy_res;
        logic       rejected;
    } out_item_t;

    // Classified item held between the front end and the sequencer.
    typedef struct packed {
        kind_t      kind;
        cmd_t       cmd;
        logic [7:0] char_code;
    } fq_entry_t;

    function automatic step_t mk(op_t op, logic [3:0] nib);
        step_t s;
        s.op  = op;
        s.nib = nib;
        return s;
    endfunction

    // Fixed nibble programs. Anything past the end of a program is OP_END.
    function automatic step_t prog_step(cmd_t cmd, logic [PTR_W-1:0] ptr);
        step_t      s;
        logic [4:0] idx;
        s   = mk(OP_END, 4'h0);
        idx = ptr[4:0];
        if (ptr < PTR_W'(PROG_LEN))
        begin
            case (cmd)
                CMD_INIT:
                begin
                    case (idx)
                        5'd0:    s = mk(OP_PW, 4'h0);
                        5'd1:    s = mk(OP_HI, 4'h2);
                        5'd2:    s = mk(OP_LO, 4'h0);
                        5'd3:    s = mk(OP_SW, 4'h0);
                        5'd4:    s = mk(OP_HI, 4'h2);
                        5'd5:    s = mk(OP_LO, 4'h0);
                        5'd6:    s = mk(OP_HI, 4'h8);
                        5'd7:    s = mk(OP_LO, 4'h0);
                        5'd8:    s = mk(OP_SW, 4'h0);
                        5'd9:    s = mk(OP_HI, 4'h0);
                        5'd10:   s = mk(OP_LO, 4'h0);
                        5'd11:   s = mk(OP_HI, 4'hF);
                        5'd12:   s = mk(OP_LO, 4'h0);
                        5'd13:   s = mk(OP_SW, 4'h0);
                        5'd14:   s = mk(OP_HI, 4'h0);
                        5'd15:   s = mk(OP_LO, 4'h0);
                        5'd16:   s = mk(OP_HI, 4'h1);
                        5'd17:   s = mk(OP_LO, 4'h0);
                        5'd18:   s = mk(OP_LW, 4'h0);
                        5'd19:   s = mk(OP_LW, 4'h0);
                        5'd20:   s = mk(OP_HI, 4'h0);
                        5'd21:   s = mk(OP_LO, 4'h0);
                        5'd22:   s = mk(OP_HI, 4'h6);
                        5'd23:   s = mk(OP_LO, 4'h0);
                        5'd24:   s = mk(OP_SW, 4'h0);
                        5'd25:   s = mk(OP_LW, 4'h0);
                        default: s = mk(OP_END, 4'h0);
                    endcase
                end
                CMD_CLEAR:
                begin
                    case (idx)
                        5'd0:    s = mk(OP_HI, 4'h0);
                        5'd1:    s = mk(OP_LO, 4'h0);
                        5'd2:    s = mk(OP_HI, 4'h1);
                        5'd3:    s = mk(OP_LO, 4'h0);
                        5'd4:    s = mk(OP_LW, 4'h0);
                        5'd5:    s = mk(OP_LW, 4'h0);
                        default: s = mk(OP_END, 4'h0);
                    endcase
                end
                CMD_CHAR:
                begin
                    case (idx)
                        5'd0:    s = mk(OP_CH, 4'h0);
                        5'd1:    s = mk(OP_LO, 4'h0);
                        5'd2:    s = mk(OP_CL, 4'h0);
                        5'd3:    s = mk(OP_LO, 4'h0);
                        5'd4:    s = mk(OP_SW, 4'h0);
                        default: s = mk(OP_END, 4'h0);
                    endcase
                end
                CMD_NEWLINE:
                begin
                    case (idx)
                        5'd0:    s = mk(OP_HI, 4'hC);
                        5'd1:    s = mk(OP_LO, 4'h0);
                        5'd2:    s = mk(OP_HI, 4'h0);
                        5'd3:    s = mk(OP_LO, 4'h0);
                        5'd4:    s = mk(OP_LW, 4'h0);
                        5'd5:    s = mk(OP_LW, 4'h0);
                        default: s = mk(OP_END, 4'h0);
                    endcase
                end
                default: s = mk(OP_END, 4'h0);
            endcase
        end
        return s;
    endfunction

endpackage

/* rtl/clnib_front.sv */
module clnib_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  clnib_pkg::in_item_t  item,
    output logic                 fq_valid,
    output clnib_pkg::fq_entry_t fq_data,
    input  logic                 fq_take
);

    clnib_pkg::fq_entry_t entry_reg [2];
    clnib_pkg::fq_entry_t classified;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    logic       take;

    // Sort the beat into tick, command or meaningless code.
    always_comb
    begin
        classified.cmd       = clnib_pkg::CMD_IDLE;
        classified.char_code = item.char_code;
        case (item.mode)
            clnib_pkg::MODE_TICK:
            begin
                classified.kind = clnib_pkg::KIND_TICK;
            end
            clnib_pkg::MODE_INIT,
            clnib_pkg::MODE_CLEAR,
            clnib_pkg::MODE_CHAR,
            clnib_pkg::MODE_NEWLINE:
            begin
                classified.kind = clnib_pkg::KIND_CMD;
                classified.cmd  = clnib_pkg::cmd_t'(item.mode);
            end
            default:
            begin
                classified.kind = clnib_pkg::KIND_IGNORE;
            end
        endcase
    end

    assign full     = (count_reg == 2'd2);
    assign accept   = push && !full;
    assign fq_valid = (count_reg != 2'd0);
    assign take     = fq_take && fq_valid;
    assign fq_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, accept} - {1'b0, take};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/clnib_exec.sv */
module clnib_exec (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_index,
    input  logic [clnib_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                   fq_valid,
    input  clnib_pkg::fq_entry_t                   fq_data,
    output logic                                   fq_take,
    input  logic                                   oq_full,
    output logic                                   oq_push,
    output clnib_pkg::out_item_t                   oq_data
);

    logic [15:0] short_wait_reg;
    logic [15:0] long_wait_reg;
    logic [19:0] power_wait_reg;

    logic [clnib_pkg::PTR_W-1:0]  ptr_reg, ptr_next;
    logic [clnib_pkg::WAIT_W-1:0] wait_reg, wait_next;
    clnib_pkg::cmd_t              cmd_reg, cmd_next;
    logic [7:0]                   char_reg, char_next;
    logic [5:0]                   pins_reg, pins_next;
    logic                         backlight_reg, backlight_next;
    logic                         busy_reg, busy_next;

    clnib_pkg::step_t             cur_step;
    clnib_pkg::step_t             after_step;
    logic [clnib_pkg::PTR_W-1:0]  ptr_inc;
    logic [clnib_pkg::WAIT_W-1:0] wait_len;
    logic [clnib_pkg::WAIT_W-1:0] wait_base;
    logic [clnib_pkg::WAIT_W-1:0] wait_dec;
    logic                         advance;
    logic                         finish;
    logic                         rejected;
    logic                         fire;

    assign fire    = fq_valid && !oq_full;
    assign fq_take = fire;
    assign oq_push = fire;

    assign ptr_inc    = ptr_reg + 1'b1;
    assign cur_step   = clnib_pkg::prog_step(cmd_reg, ptr_reg);
    assign after_step = clnib_pkg::prog_step(cmd_reg, ptr_inc);

    always_comb
    begin
        case (cur_step.op)
            clnib_pkg::OP_SW: wait_len = {4'd0, short_wait_reg};
            clnib_pkg::OP_LW: wait_len = {4'd0, long_wait_reg};
            default:          wait_len = power_wait_reg;
        endcase
        if (wait_len == '0)
        begin
            wait_len = clnib_pkg::WAIT_W'(1);
        end
        wait_base = (wait_reg == '0) ? wait_len : wait_reg;
        wait_dec  = wait_base - 1'b1;
    end

    always_comb
    begin
        ptr_next       = ptr_reg;
        wait_next      = wait_reg;
        cmd_next       = cmd_reg;
        char_next      = char_reg;
        pins_next      = pins_reg;
        backlight_next = backlight_reg;
        busy_next      = busy_reg;
        advance        = 1'b0;
        finish         = 1'b0;
        rejected       = 1'b0;

        case (fq_data.kind)
            clnib_pkg::KIND_TICK:
            begin
                if (busy_reg)
                begin
                    case (cur_step.op)
                        clnib_pkg::OP_HI:
                        begin
                            pins_next = {2'b01, cur_step.nib};
                            advance   = 1'b1;
                        end
                        clnib_pkg::OP_LO:
                        begin
                            pins_next = pins_reg;
                            pins_next[clnib_pkg::PIN_EN_BIT] = 1'b0;
                            advance   = 1'b1;
                        end
                        clnib_pkg::OP_CH:
                        begin
                            pins_next = {2'b11, char_reg[7:4]};
                            advance   = 1'b1;
                        end
                        clnib_pkg::OP_CL:
                        begin
                            pins_next = {2'b11, char_reg[3:0]};
                            advance   = 1'b1;
                        end
                        clnib_pkg::OP_SW,
                        clnib_pkg::OP_LW,
                        clnib_pkg::OP_PW:
                        begin
                            wait_next = wait_dec;
                            advance   = (wait_dec == '0);
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                    if (advance)
                    begin
                        ptr_next = ptr_inc;
                        if (after_step.op == clnib_pkg::OP_END)
                        begin
                            finish = 1'b1;
                        end
                    end
                    if (finish)
                    begin
                        if (cmd_reg == clnib_pkg::CMD_INIT)
                        begin
                            backlight_next = 1'b1;
                        end
                        busy_next = 1'b0;
                        cmd_next  = clnib_pkg::CMD_IDLE;
                        ptr_next  = '0;
                        wait_next = '0;
                    end
                end
            end
            clnib_pkg::KIND_CMD:
            begin
                if (busy_reg)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    cmd_next  = fq_data.cmd;
                    ptr_next  = '0;
                    wait_next = '0;
                    busy_next = 1'b1;
                    if (fq_data.cmd == clnib_pkg::CMD_CHAR)
                    begin
                        char_next = fq_data.char_code;
                    end
                end
            end
            default:
            begin
                rejected = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        oq_data.reg_select  = pins_next[clnib_pkg::PIN_RS_BIT];
        oq_data.enable_pin  = pins_next[clnib_pkg::PIN_EN_BIT];
        oq_data.data_nibble = pins_next[3:0];
        oq_data.backlight   = backlight_next;
        oq_data.busy_res    = busy_next;
        oq_data.rejected    = rejected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_wait_reg <= clnib_pkg::SHORT_WAIT_RESET;
            long_wait_reg  <= clnib_pkg::LONG_WAIT_RESET;
            power_wait_reg <= clnib_pkg::POWER_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            case (clnib_pkg::cfg_index_t'(cfg_index))
                clnib_pkg::CFG_SHORT_WAIT: short_wait_reg <= cfg_data[15:0];
                clnib_pkg::CFG_LONG_WAIT:  long_wait_reg  <= cfg_data[15:0];
                clnib_pkg::CFG_POWER_WAIT: power_wait_reg <= cfg_data[19:0];
                default:                   power_wait_reg <= power_wait_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            wait_reg      <= '0;
            cmd_reg       <= clnib_pkg::CMD_IDLE;
            char_reg      <= '0;
            pins_reg      <= '0;
            backlight_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else if (fire)
        begin
            ptr_reg       <= ptr_next;
            wait_reg      <= wait_next;
            cmd_reg       <= cmd_next;
            char_reg      <= char_next;
            pins_reg      <= pins_next;
            backlight_reg <= backlight_next;
            busy_reg      <= busy_next;
        end
    end

endmodule

/* rtl/clnib_outq.sv */
module clnib_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 oq_push,
    input  clnib_pkg::out_item_t oq_data,
    output logic                 oq_full,
    output logic                 empty,
    input  logic                 pop,
    output clnib_pkg::out_item_t result
);

    clnib_pkg::out_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       wr;
    logic       rd;

    assign oq_full = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign wr      = oq_push && !oq_full;
    assign rd      = pop && !empty;
    assign result  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= oq_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/char_lcd_nibble_sequencer_unit.sv */
// Channel    | Handshake          | Payload                     | Beat accepted when
// -----------+--------------------+-----------------------------+--------------------
// input      | push / full        | item (clnib_pkg::in_item_t) | push && !full
// result     | empty / pop        | result (out_item_t)         | pop && !empty
// config     | cfg_we             | cfg_index, cfg_data         | cfg_we
//
// One input beat is taken every clock while full is low, and each one yields exactly one result beat.
// An accepted beat is written into the front queue; the sequencer steps it out of
// the front queue when the output queue has room and writes it into the output queue.
// Reset clears both queues and the sequencer and loads the default wait lengths.
// full rises when the two-entry front queue holds two beats, which happens only
// after the output queue has filled because nobody pops.

module char_lcd_nibble_sequencer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  clnib_pkg::in_item_t              item,
    output logic                             empty,
    input  logic                             pop,
    output clnib_pkg::out_item_t             result,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [clnib_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Classified beats waiting for the sequencer.
    logic                 fq_valid;
    clnib_pkg::fq_entry_t fq_data;
    logic                 fq_take;

    // Finished result beats going into the output queue.
    logic                 oq_full;
    logic                 oq_push;
    clnib_pkg::out_item_t oq_data;

    // The front end sorts each beat into tick, command or meaningless code and
    // buffers it, so input acceptance does not wait on the sequencer.
    clnib_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .fq_valid (fq_valid),
        .fq_data  (fq_data),
        .fq_take  (fq_take)
    );

    // The sequencer owns the program pointer, the wait counter and the pin
    // register. A tick while busy drives one nibble step or counts down a wait;
    // a command loads a program when idle and is flagged as rejected otherwise.
    // It runs whenever a beat is queued and the output queue has room.
    clnib_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fq_valid  (fq_valid),
        .fq_data   (fq_data),
        .fq_take   (fq_take),
        .oq_full   (oq_full),
        .oq_push   (oq_push),
        .oq_data   (oq_data)
    );

    // The output queue holds finished results until the consumer pops them.
    clnib_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .oq_push (oq_push),
        .oq_data (oq_data),
        .oq_full (oq_full),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

/* tb/tb.sv */
module tb;

    import clnib_pkg::*;

    // Modes five to seven have no meaning and are ignored by the block.
    localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT = 4000;

    // Length of the one long hold-off on the result side, in cycles.
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       push = 1'b0;
    logic       full;
    in_item_t   item = '0;
    logic       empty;
    logic       pop = 1'b0;
    out_item_t  result;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_SHORT_WAIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    char_lcd_nibble_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state. This is a private copy of the sequencer: the wait
    // lengths, the program position and the pins it has driven so far.
    // ------------------------------------------------------------------
    logic [15:0] short_len = SHORT_WAIT_RESET;
    logic [15:0] long_len  = LONG_WAIT_RESET;
    logic [19:0] power_len = POWER_WAIT_RESET;

    logic [5:0]  seq_ptr      = '0;
    logic [19:0] wait_left    = '0;
    cmd_t        seq_cmd      = CMD_IDLE;
    logic [7:0]  latched_char = '0;
    logic [5:0]  pins         = '0;
    logic        bl_on        = 1'b0;
    logic        seq_busy     = 1'b0;

    // Beats waiting to be offered, and the pin states expected back.
    in_item_t  queued_items[$];
    out_item_t expected_pins[$];

    int items_sent  = 0;
    int beats_seen  = 0;
    int fail_count  = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    out_item_t exp_beat;

    // The nibble programs, one step per entry. Every nibble is an EN-high
    // step followed by an EN-low step; waits sit before, between and after nibbles.
    function automatic step_t program_step(cmd_t c, logic [5:0] ptr);
        step_t s;
        s = {OP_END, 4'h0};
        case (c)
            CMD_INIT:
            begin
                case (ptr)
                    6'd0:  s = {OP_PW, 4'h0};
                    6'd1:  s = {OP_HI, 4'h2};
                    6'd2:  s = {OP_LO, 4'h0};
                    6'd3:  s = {OP_SW, 4'h0};
                    6'd4:  s = {OP_HI, 4'h2};
                    6'd5:  s = {OP_LO, 4'h0};
                    6'd6:  s = {OP_HI, 4'h8};
                    6'd7:  s = {OP_LO, 4'h0};
                    6'd8:  s = {OP_SW, 4'h0};
                    6'd9:  s = {OP_HI, 4'h0};
                    6'd10: s = {OP_LO, 4'h0};
                    6'd11: s = {OP_HI, 4'hF};
                    6'd12: s = {OP_LO, 4'h0};
                    6'd13: s = {OP_SW, 4'h0};
                    6'd14: s = {OP_HI, 4'h0};
                    6'd15: s = {OP_LO, 4'h0};
                    6'd16: s = {OP_HI, 4'h1};
                    6'd17: s = {OP_LO, 4'h0};
                    6'd18: s = {OP_LW, 4'h0};
                    6'd19: s = {OP_LW, 4'h0};
                    6'd20: s = {OP_HI, 4'h0};
                    6'd21: s = {OP_LO, 4'h0};
                    6'd22: s = {OP_HI, 4'h6};
                    6'd23: s = {OP_LO, 4'h0};
                    6'd24: s = {OP_SW, 4'h0};
                    6'd25: s = {OP_LW, 4'h0};
                    default: s = {OP_END, 4'h0};
                endcase
            end
            CMD_CLEAR, CMD_NEWLINE:
            begin
                // Both send one command byte and then wait two long waits.
                case (ptr)
                    6'd0:  s = {OP_HI, (c == CMD_NEWLINE) ? 4'hC : 4'h0};
                    6'd1:  s = {OP_LO, 4'h0};
                    6'd2:  s = {OP_HI, (c == CMD_NEWLINE) ? 4'h0 : 4'h1};
                    6'd3:  s = {OP_LO, 4'h0};
                    6'd4:  s = {OP_LW, 4'h0};
                    6'd5:  s = {OP_LW, 4'h0};
                    default: s = {OP_END, 4'h0};
                endcase
            end
            CMD_CHAR:
            begin
                case (ptr)
                    6'd0:  s = {OP_CH, 4'h0};
                    6'd1:  s = {OP_LO, 4'h0};
                    6'd2:  s = {OP_CL, 4'h0};
                    6'd3:  s = {OP_LO, 4'h0};
                    6'd4:  s = {OP_SW, 4'h0};
                    default: s = {OP_END, 4'h0};
                endcase
            end
            default: s = {OP_END, 4'h0};
        endcase
        return s;
    endfunction

    function automatic void end_program();
        if (seq_cmd == CMD_INIT)
            bl_on = 1'b1;
        seq_busy  = 1'b0;
        seq_cmd   = CMD_IDLE;
        seq_ptr   = '0;
        wait_left = '0;
    endfunction

    // One tick of a running program: drive a nibble edge or count a wait.
    function automatic void run_program_step();
        step_t       s;
        step_t       upcoming;
        logic [19:0] len;
        logic        moved;
        s     = program_step(seq_cmd, seq_ptr);
        moved = 1'b0;
        len   = '0;
        case (s.op)
            OP_HI:
            begin
                pins  = {2'b01, s.nib};
                moved = 1'b1;
            end
            OP_LO:
            begin
                pins[PIN_EN_BIT] = 1'b0;
                moved = 1'b1;
            end
            OP_CH:
            begin
                pins  = {2'b11, latched_char[7:4]};
                moved = 1'b1;
            end
            OP_CL:
            begin
                pins  = {2'b11, latched_char[3:0]};
                moved = 1'b1;
            end
            OP_SW, OP_LW, OP_PW:
            begin
                if (s.op == OP_SW)
                    len = {4'h0, short_len};
                else if (s.op == OP_LW)
                    len = {4'h0, long_len};
                else
                    len = power_len;
                // A programmed length of zero still costs one tick.
                if (len == '0)
                    len = 20'd1;
                if (wait_left == '0)
                    wait_left = len;
                wait_left = wait_left - 20'd1;
                moved = (wait_left == '0);
            end
            default:
            begin
                end_program();
                return;
            end
        endcase
        if (moved)
        begin
            seq_ptr  = seq_ptr + 6'd1;
            upcoming = program_step(seq_cmd, seq_ptr);
            if (upcoming.op == OP_END)
                end_program();
        end
    endfunction

    // Work out the pin state that one accepted input beat leaves behind.
    function automatic out_item_t predict_pins(in_item_t it);
        out_item_t r;
        logic      rej;
        rej = 1'b0;
        if (it.mode == MODE_TICK)
        begin
            if (seq_busy)
                run_program_step();
        end
        else if (it.mode <= MODE_NEWLINE)
        begin
            // A command only loads the program; the first step needs a tick.
            if (seq_busy)
                rej = 1'b1;
            else
            begin
                seq_cmd   = cmd_t'(it.mode);
                seq_ptr   = '0;
                wait_left = '0;
                seq_busy  = 1'b1;
                if (it.mode == MODE_CHAR)
                    latched_char = it.char_code;
            end
        end
        r.reg_select  = pins[PIN_RS_BIT];
        r.enable_pin  = pins[PIN_EN_BIT];
        r.data_nibble = pins[3:0];
        r.backlight   = bl_on;
        r.busy_res    = seq_busy;
        r.rejected    = rej;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver. It offers the queued beats in order and feeds the predictor
    // with every beat that the block accepts. Outside a quiet window it
    // leaves push low at random, with a chance of seven in a hundred.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_pins.push_back(predict_pins(item));
                items_sent++;
            end
            if (!push || !full)
            begin
                if (queued_items.size() != 0 &&
                    !((items_sent < 200 || items_sent >= 450) && $urandom_range(99) < 7))
                begin
                    item <= queued_items.pop_front();
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor. Every popped beat is held against the oldest expectation.
    // Once, while a good number of beats are still queued, it stops popping
    // for a long stretch so that the block backs up and raises full.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                beats_seen++;
                if (expected_pins.size() == 0)
                begin
                    $error("result beat arrived with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_beat = expected_pins.pop_front();
                    check_field("reg_select", exp_beat.reg_select, result.reg_select);
                    check_field("enable_pin", exp_beat.enable_pin, result.enable_pin);
                    check_field("data_nibble", exp_beat.data_nibble, result.data_nibble);
                    check_field("backlight", exp_beat.backlight, result.backlight);
                    check_field("busy_res", exp_beat.busy_res, result.busy_res);
                    check_field("rejected", exp_beat.rejected, result.rejected);
                end
            end
            if (hold_left != 0)
                hold_left--;
            else if (!hold_done && queued_items.size() >= 40 && beats_seen >= 100)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            pop <= (hold_left == 0) &&
                   !((beats_seen < 200 || beats_seen >= 450) && $urandom_range(99) < 7);
        end
    end

    // The watchdog ends a run in which no beat moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void send(logic [2:0] mode, logic [7:0] code);
        in_item_t it;
        it.mode      = mode;
        it.char_code = code;
        queued_items.push_back(it);
    endfunction

    // Number of tick beats a program needs under the current wait lengths.
    function automatic int ticks_for(logic [2:0] mode);
        int sw;
        int lw;
        int pw;
        sw = (short_len == 0) ? 1 : short_len;
        lw = (long_len == 0) ? 1 : long_len;
        pw = (power_len == 0) ? 1 : power_len;
        case (mode)
            MODE_INIT:    return 18 + pw + 4 * sw + 3 * lw;
            MODE_CHAR:    return 4 + sw;
            MODE_CLEAR,
            MODE_NEWLINE: return 4 + 2 * lw;
            default:      return 0;
        endcase
    endfunction

    // A command followed by exactly the ticks it needs. While it runs, some
    // ticks are preceded by a command that must be rejected, or by a beat
    // with an unused mode. Returns the number of beats that are not ignored.
    function automatic int queue_program(logic [2:0] mode, logic [7:0] code, int noise_pct);
        int n;
        int counted;
        n       = ticks_for(mode);
        counted = 1 + n;
        send(mode, code);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                if ($urandom_range(1))
                begin
                    send(3'($urandom_range(MODE_NEWLINE, MODE_INIT)),
                         8'($urandom_range(255)));
                    counted++;
                end
                else
                    send(MODE_FIRST_UNUSED + 3'($urandom_range(2)), 8'($urandom_range(255)));
            end
            send(MODE_TICK, 8'($urandom_range(255)));
        end
        return counted;
    endfunction

    // All three wait lengths are written back to back while the block idles.
    // The top bits of cfg_data unused by the 16-bit registers carry random junk.
    task automatic load_wait_lengths(logic [15:0] s, logic [15:0] l, logic [19:0] p);
        logic [3:0] junk;
        junk = 4'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SHORT_WAIT;
        cfg_data  <= {junk, s};
        @(posedge clk);
        junk = 4'($urandom);
        cfg_index <= CFG_LONG_WAIT;
        cfg_data  <= {junk, l};
        @(posedge clk);
        cfg_index <= CFG_POWER_WAIT;
        cfg_data  <= p;
        @(posedge clk);
        cfg_we    <= 1'b0;
        short_len = s;
        long_len  = l;
        power_len = p;
    endtask

    // The sender holds back until every queued beat has come back checked.
    // Sampling on the falling edge keeps this clear of the clocked blocks.
    task automatic wait_until_drained();
        @(negedge clk);
        while (queued_items.size() != 0 || push || expected_pins.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int random_items;
        int n_cmds;
        int pick;
        int dummy;
        logic [15:0] sw;

        random_items = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Shortest waits. A tick and the unused modes while idle do nothing.
        // During init every command is refused, and an unused mode is ignored.
        load_wait_lengths(16'd1, 16'd1, 20'd1);
        send(MODE_TICK, 8'h00);
        send(MODE_FIRST_UNUSED, 8'hFF);
        send(MODE_FIRST_UNUSED + 3'd1, 8'h00);
        send(MODE_FIRST_UNUSED + 3'd2, 8'hFF);
        send(MODE_INIT, 8'h00);
        send(MODE_INIT, 8'h11);
        send(MODE_CLEAR, 8'h22);
        send(MODE_CHAR, 8'h33);
        send(MODE_NEWLINE, 8'h44);
        send(MODE_FIRST_UNUSED + 3'd2, 8'h55);
        for (int k = 0; k < ticks_for(MODE_INIT); k++)
            send(MODE_TICK, 8'hFF);
        dummy = queue_program(MODE_CHAR, 8'hFF, 0);
        dummy = queue_program(MODE_CHAR, 8'h00, 0);
        dummy = queue_program(MODE_CLEAR, 8'h00, 0);
        dummy = queue_program(MODE_NEWLINE, 8'hFF, 0);
        send(MODE_TICK, 8'h00);
        wait_until_drained();

        // Zero lengths behave as one tick. A second init leaves the
        // backlight on.
        load_wait_lengths(16'd0, 16'd0, 20'd0);
        dummy = queue_program(MODE_INIT, 8'h00, 0);
        dummy = queue_program(MODE_CHAR, 8'hA5, 0);
        wait_until_drained();

        // Random part: mostly complete programs with random content, with
        // refused commands, ignored modes and idle ticks mixed in.
        while (random_items < 560)
        begin
            sw = ($urandom_range(9) == 0) ? 16'($urandom_range(40, 7))
                                          : 16'($urandom_range(6, 1));
            load_wait_lengths(sw, 16'($urandom_range(8, 1)), 20'($urandom_range(30, 1)));
            n_cmds = $urandom_range(16, 8);
            for (int c = 0; c < n_cmds; c++)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    random_items += queue_program(MODE_CHAR, 8'($urandom_range(255)), 10);
                else if (pick < 70)
                    random_items += queue_program(MODE_CLEAR, 8'($urandom_range(255)), 10);
                else if (pick < 85)
                    random_items += queue_program(MODE_NEWLINE, 8'($urandom_range(255)), 10);
                else
                    random_items += queue_program(MODE_INIT, 8'($urandom_range(255)), 10);
                if ($urandom_range(4) == 0)
                begin
                    repeat ($urandom_range(3, 1))
                    begin
                        send(MODE_TICK, 8'($urandom_range(255)));
                        random_items++;
                    end
                end
            end
            wait_until_drained();
        end

        // Full-width long and power-up lengths. Running them would take far
        // too many ticks, so only a character with a short wait runs here.
        load_wait_lengths(16'd2, 16'hFFFF, 20'hFFFFF);
        dummy = queue_program(MODE_CHAR, 8'h5A, 0);
        wait_until_drained();

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* char_lcd_nibble_sequencer_unit.f */
rtl/clnib_pkg.sv
rtl/clnib_front.sv
rtl/clnib_exec.sv
rtl/clnib_outq.sv
rtl/char_lcd_nibble_sequencer_unit.sv
tb/tb.sv
